/* design/sbvm_pkg.sv */
package sbvm_pkg;

	typedef enum logic [4:0] {
		OP_HALT   = 5'd0,
		OP_NOP    = 5'd1,
		OP_PUSH   = 5'd2,
		OP_POP    = 5'd3,
		OP_ADD    = 5'd4,
		OP_SUB    = 5'd5,
		OP_MUL    = 5'd6,
		OP_DIV    = 5'd7,
		OP_NEG    = 5'd8,
		OP_EQ     = 5'd9,
		OP_LT     = 5'd10,
		OP_GT     = 5'd11,
		OP_JMP    = 5'd12,
		OP_JMPF   = 5'd13,
		OP_LOAD   = 5'd14,
		OP_STORE  = 5'd15,
		OP_ARRAY  = 5'd16,
		OP_ALOAD  = 5'd17,
		OP_ASTORE = 5'd18,
		OP_CALL   = 5'd19,
		OP_RET    = 5'd20
	} opcode_t;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_OVERFLOW  = 4'd1;
	localparam logic [3:0] ERR_UNDERFLOW = 4'd2;
	localparam logic [3:0] ERR_DIV_ZERO  = 4'd3;
	localparam logic [3:0] ERR_SLOT      = 4'd4;
	localparam logic [3:0] ERR_BAD_REQ   = 4'd5;
	localparam logic [3:0] ERR_STORE_FULL = 4'd6;
	localparam logic [3:0] ERR_BAD_ID    = 4'd7;
	localparam logic [3:0] ERR_INDEX     = 4'd8;
	localparam logic [3:0] ERR_BAD_CALL  = 4'd9;
	localparam logic [3:0] ERR_CALL_OVER = 4'd10;
	localparam logic [3:0] ERR_CALL_UNDER = 4'd11;
	localparam logic [3:0] ERR_UNKNOWN   = 4'd12;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_DIV, S_DIVW, S_COPY,
		S_ADESC, S_AWRD, S_CALL, S_RETW, S_TOP, S_FIN
	} state_t;

	typedef enum logic [2:0] {
		CL_SIMPLE, CL_DIV, CL_ARRAY, CL_AACC, CL_CALL, CL_RET
	} cls_t;

	typedef struct packed {
		state_t st;
		logic   load;
	} cmd_t;

	typedef struct packed {
		logic stopped;
		logic exec_err;
		logic desc_err;
		logic is_aload;
		logic div_last;
		logic copy_last;
		logic call_last;
		logic out_free;
		cls_t cls;
	} stat_t;

endpackage

/* design/sbvm_ctrl.sv */
module sbvm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sbvm_pkg::stat_t stat,
	output sbvm_pkg::cmd_t  cmd
);
	import sbvm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = stat.stopped ? S_FIN : S_RD1;
				end
			end
			S_RD1: state_d = S_RD2;
			S_RD2: state_d = S_RD3;
			S_RD3: state_d = S_EXEC;
			S_EXEC: begin
				if (stat.exec_err) begin
					state_d = S_TOP;
				end else begin
					unique case (stat.cls)
						CL_DIV:   state_d = S_DIV;
						CL_ARRAY: state_d = S_COPY;
						CL_AACC:  state_d = S_ADESC;
						CL_CALL:  state_d = S_CALL;
						CL_RET:   state_d = S_RETW;
						default:  state_d = S_TOP;
					endcase
				end
			end
			S_DIV:   state_d = stat.div_last ? S_DIVW : S_DIV;
			S_DIVW:  state_d = S_TOP;
			S_COPY:  state_d = stat.copy_last ? S_TOP : S_COPY;
			S_ADESC: state_d = (!stat.desc_err && stat.is_aload) ? S_AWRD : S_TOP;
			S_AWRD:  state_d = S_TOP;
			S_CALL:  state_d = stat.call_last ? S_TOP : S_CALL;
			S_RETW:  state_d = S_TOP;
			S_TOP:   state_d = S_FIN;
			S_FIN:   state_d = stat.out_free ? S_IDLE : S_FIN;
			default: state_d = S_IDLE;
		endcase
		cmd.st = state_q;
		cmd.load = in_ready && in_valid;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && stat.stopped) |=> (state_q == S_FIN))
		else $error("stopped item did not go straight to result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD1) |=> (state_q == S_RD2))
		else $error("operand read sequence broken");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOP) |=> (state_q == S_FIN))
		else $error("top read not followed by result");

endmodule

/* design/sbvm_dp.sv */
module sbvm_dp #(
	parameter int STACK_DEPTH      = 1024,
	parameter int SLOT_COUNT       = 256,
	parameter int ARRAY_SLOTS      = 1024,
	parameter int ARRAY_WORD_COUNT = 4096,
	parameter int CALL_DEPTH       = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbvm_pkg::cmd_t     cmd,
	output sbvm_pkg::stat_t    stat,
	input  logic [4:0]         op,
	input  logic [7:0]         imm,
	input  logic [15:0]        target,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_ip,
	output logic               halted,
	output logic signed [31:0] value,
	output logic [3:0]         error
);
	import sbvm_pkg::*;

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int SW  = $clog2(SLOT_COUNT);
	localparam int AIW = $clog2(ARRAY_SLOTS);
	localparam int ACW = $clog2(ARRAY_SLOTS + 1);
	localparam int WAW = $clog2(ARRAY_WORD_COUNT);
	localparam int WCW = $clog2(ARRAY_WORD_COUNT + 1);
	localparam int CAW = $clog2(CALL_DEPTH);
	localparam int CCW = $clog2(CALL_DEPTH + 1);
	localparam int KW  = (WCW > SW + 1) ? WCW : SW + 1;

	// Memories.
	logic [31:0]  stk_mem [STACK_DEPTH];
	logic [31:0]  slot_mem [SLOT_COUNT];
	logic [WAW-1:0] dbase_mem [ARRAY_SLOTS];
	logic [WCW-1:0] dlen_mem [ARRAY_SLOTS];
	logic [31:0]  word_mem [ARRAY_WORD_COUNT];
	logic [15:0]  csip_mem [CALL_DEPTH];
	logic [SW-1:0] csfb_mem [CALL_DEPTH];

	// Architectural and working registers.
	logic [4:0]   op_q;
	logic [7:0]   imm_q;
	logic [15:0]  tgt_q, pc_q;
	logic [SCW-1:0] cnt_q;
	logic [SW-1:0] fb_q;
	logic [ACW-1:0] acnt_q;
	logic [WCW-1:0] wused_q;
	logic [CCW-1:0] ccnt_q;
	logic         stopped_q, stop_in_q, halt_q;
	logic [3:0]   err_q;
	logic [31:0]  t1_q, t2_q, sd_q, slot_q, wd_q;
	logic         slot_vq;
	logic [SLOT_COUNT-1:0] slot_v_q;
	logic [WAW-1:0] dbase_q;
	logic [WCW-1:0] dlen_q;
	logic [15:0]  csip_q;
	logic [SW-1:0] csfb_q;
	logic [KW-1:0] k_q;
	logic [31:0]  dv_n_q, dv_d_q, dv_r_q;
	logic [4:0]   dv_k_q;
	logic         dv_neg_q;
	logic         out_valid_q;
	logic [15:0]  nip_out_q;
	logic         halted_out_q;
	logic [31:0]  value_out_q;
	logic [3:0]   err_out_q;

	// Derived values.
	logic [SCW-1:0] c_m1, c_m2, c_m3, base_c;
	logic c_ge1, c_ge2, c_ge3, c_full, imm_bad;
	logic [3:0]  err_e;
	logic        ex_ok, desc_bad, is_aload;
	logic [31:0] alu_v, t3, aid, aidx, div_res;
	logic [KW-1:0] sz_k, na_k;
	logic [32:0] r_sh, r_diff, fb_sum;
	logic [WCW-1:0] elem_addr;
	cls_t cls;

	logic         st_we, st_re;
	logic [SCW-1:0] st_wa, st_ra;
	logic [31:0]  st_wd;
	logic         sl_we;
	logic [SW-1:0] sl_wa;
	logic [31:0]  sl_wd;
	logic         wm_we;
	logic [WCW-1:0] wm_wa;
	logic [31:0]  wm_wd;

	assign c_m1 = cnt_q - SCW'(1);
	assign c_m2 = cnt_q - SCW'(2);
	assign c_m3 = cnt_q - SCW'(3);
	assign c_ge1 = (cnt_q != '0);
	assign c_ge2 = (cnt_q >= SCW'(2));
	assign c_ge3 = (cnt_q >= SCW'(3));
	assign c_full = (cnt_q >= SCW'(STACK_DEPTH));
	assign imm_bad = (32'(imm_q) >= 32'(SLOT_COUNT));
	assign t3 = sd_q;
	assign is_aload = (op_q == OP_ALOAD);
	assign aid = is_aload ? t2_q : t3;
	assign aidx = is_aload ? t1_q : t2_q;
	assign sz_k = t1_q[KW-1:0];
	assign na_k = t2_q[KW-1:0];
	assign base_c = c_m1 - SCW'(t1_q);
	assign fb_sum = {1'b0, t2_q} + 33'(fb_q);
	assign desc_bad = aidx[31] || (aidx >= 32'(dlen_q));
	assign elem_addr = WCW'(dbase_q) + WCW'(aidx);
	assign r_sh = {dv_r_q, dv_n_q[31]};
	assign r_diff = r_sh - {1'b0, dv_d_q};
	assign div_res = dv_neg_q ? (32'd0 - dv_n_q) : dv_n_q;

	always_comb begin
		unique case (op_q) inside
			OP_ADD:  alu_v = t2_q + t1_q;
			OP_SUB:  alu_v = t2_q - t1_q;
			OP_MUL:  alu_v = t2_q * t1_q;
			OP_EQ:   alu_v = {31'd0, t2_q == t1_q};
			OP_LT:   alu_v = {31'd0, $signed(t2_q) < $signed(t1_q)};
			default: alu_v = {31'd0, $signed(t1_q) < $signed(t2_q)};
		endcase
	end

	// Ordered error checks; a hit only sets stopped_q and err_q.
	always_comb begin
		err_e = ERR_NONE;
		cls = CL_SIMPLE;
		unique case (op_q) inside
			OP_NOP, OP_JMP: err_e = ERR_NONE;
			OP_HALT, OP_POP, OP_NEG, OP_JMPF: begin
				if (!c_ge1) err_e = ERR_UNDERFLOW;
			end
			OP_PUSH: begin
				if (c_full) err_e = ERR_OVERFLOW;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_GT: begin
				if (!c_ge2) err_e = ERR_UNDERFLOW;
			end
			OP_DIV: begin
				cls = CL_DIV;
				if (!c_ge1) err_e = ERR_UNDERFLOW;
				else if (t1_q == 32'd0) err_e = ERR_DIV_ZERO;
				else if (!c_ge2) err_e = ERR_UNDERFLOW;
			end
			OP_LOAD: begin
				if (imm_bad) err_e = ERR_SLOT;
				else if (c_full) err_e = ERR_OVERFLOW;
			end
			OP_STORE: begin
				if (imm_bad) err_e = ERR_SLOT;
				else if (!c_ge1) err_e = ERR_UNDERFLOW;
			end
			OP_ARRAY: begin
				cls = CL_ARRAY;
				if (!c_ge1) err_e = ERR_UNDERFLOW;
				else if (t1_q[31] || t1_q == 32'd0 || acnt_q >= ACW'(ARRAY_SLOTS))
					err_e = ERR_BAD_REQ;
				else if (t1_q > 32'(ARRAY_WORD_COUNT) - 32'(wused_q))
					err_e = ERR_STORE_FULL;
				else if (32'(cnt_q) - 32'd1 < t1_q) err_e = ERR_UNDERFLOW;
			end
			OP_ALOAD, OP_ASTORE: begin
				cls = CL_AACC;
				if (is_aload ? !c_ge2 : !c_ge3) err_e = ERR_UNDERFLOW;
				else if (aid[31] || aid >= 32'(acnt_q)) err_e = ERR_BAD_ID;
			end
			OP_CALL: begin
				cls = CL_CALL;
				if (!c_ge2) err_e = ERR_UNDERFLOW;
				else if (t1_q[31:16] != 16'd0 || t2_q[31] ||
					fb_sum >= 33'(SLOT_COUNT)) err_e = ERR_BAD_CALL;
				else if (ccnt_q >= CCW'(CALL_DEPTH)) err_e = ERR_CALL_OVER;
				else if (32'(cnt_q) - 32'd2 < t2_q) err_e = ERR_UNDERFLOW;
			end
			OP_RET: begin
				cls = CL_RET;
				if (!c_ge1) err_e = ERR_UNDERFLOW;
				else if (ccnt_q == '0) err_e = ERR_CALL_UNDER;
			end
			default: err_e = ERR_UNKNOWN;
		endcase
	end

	assign ex_ok = (cmd.st == S_EXEC) && (err_e == ERR_NONE);

	// Operand stack ports.
	always_comb begin
		st_re = 1'b1;
		st_ra = '0;
		unique case (cmd.st)
			S_RD1:  st_ra = c_m1;
			S_RD2:  st_ra = c_m2;
			S_RD3:  st_ra = c_m3;
			S_COPY: st_ra = base_c + SCW'(k_q);
			S_CALL: st_ra = c_m3 - SCW'(k_q);
			S_TOP:  st_ra = c_m1;
			default: st_re = 1'b0;
		endcase
		st_we = 1'b0;
		st_wa = '0;
		st_wd = '0;
		if (ex_ok) begin
			unique case (op_q) inside
				OP_PUSH: begin
					st_we = 1'b1; st_wa = cnt_q; st_wd = 32'(imm_q);
				end
				OP_LOAD: begin
					st_we = 1'b1; st_wa = cnt_q; st_wd = slot_vq ? slot_q : 32'd0;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_GT: begin
					st_we = 1'b1; st_wa = c_m2; st_wd = alu_v;
				end
				OP_NEG: begin
					st_we = 1'b1; st_wa = c_m1; st_wd = 32'd0 - t1_q;
				end
				default: st_we = 1'b0;
			endcase
		end else if (cmd.st == S_COPY && k_q == sz_k) begin
			st_we = 1'b1; st_wa = base_c; st_wd = 32'(acnt_q);
		end else if (cmd.st == S_ADESC && !desc_bad && !is_aload) begin
			st_we = 1'b1; st_wa = c_m3; st_wd = t1_q;
		end else if (cmd.st == S_AWRD) begin
			st_we = 1'b1; st_wa = c_m2; st_wd = wd_q;
		end else if (cmd.st == S_DIVW) begin
			st_we = 1'b1; st_wa = c_m2; st_wd = div_res;
		end
	end

	// Slot and array word write ports.
	always_comb begin
		sl_we = 1'b0;
		sl_wa = '0;
		sl_wd = t1_q;
		if (ex_ok && op_q == OP_STORE) begin
			sl_we = 1'b1;
			sl_wa = SW'(imm_q);
		end else if (cmd.st == S_CALL && k_q != '0) begin
			sl_we = 1'b1;
			sl_wa = fb_q + SW'(k_q) - SW'(1);
			sl_wd = sd_q;
		end
		wm_we = 1'b0;
		wm_wa = '0;
		wm_wd = t1_q;
		if (cmd.st == S_COPY && k_q != '0) begin
			wm_we = 1'b1;
			wm_wa = wused_q + WCW'(k_q) - WCW'(1);
			wm_wd = sd_q;
		end else if (cmd.st == S_ADESC && !desc_bad && !is_aload) begin
			wm_we = 1'b1;
			wm_wa = elem_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) stk_mem[st_wa[SAW-1:0]] <= st_wd;
		if (st_re) sd_q <= stk_mem[st_ra[SAW-1:0]];
		if (sl_we) slot_mem[sl_wa] <= sl_wd;
		if (cmd.st == S_RD1) slot_q <= slot_mem[SW'(imm_q)];
		if (wm_we) word_mem[wm_wa[WAW-1:0]] <= wm_wd;
		if (cmd.st == S_ADESC) wd_q <= word_mem[elem_addr[WAW-1:0]];
		if (cmd.st == S_COPY && k_q == sz_k) begin
			dbase_mem[acnt_q[AIW-1:0]] <= wused_q[WAW-1:0];
			dlen_mem[acnt_q[AIW-1:0]] <= WCW'(t1_q);
		end
		if (cmd.st == S_EXEC) begin
			dbase_q <= dbase_mem[aid[AIW-1:0]];
			dlen_q <= dlen_mem[aid[AIW-1:0]];
		end
		if (ex_ok && op_q == OP_CALL) begin
			csip_mem[ccnt_q[CAW-1:0]] <= pc_q + 16'd2;
			csfb_mem[ccnt_q[CAW-1:0]] <= fb_q;
		end
		if (cmd.st == S_EXEC) begin
			csip_q <= csip_mem[c_cs_ra()];
			csfb_q <= csfb_mem[c_cs_ra()];
		end
	end

	function automatic logic [CAW-1:0] c_cs_ra();
		logic [CCW-1:0] a;
		a = ccnt_q - CCW'(1);
		return a[CAW-1:0];
	endfunction

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			imm_q <= imm;
			tgt_q <= target;
		end
		if (cmd.st == S_RD2) t1_q <= sd_q;
		if (cmd.st == S_RD3) t2_q <= sd_q;
		if (cmd.st == S_EXEC) begin
			dv_n_q <= t2_q[31] ? 32'd0 - t2_q : t2_q;
			dv_d_q <= t1_q[31] ? 32'd0 - t1_q : t1_q;
			dv_r_q <= '0;
			dv_neg_q <= t2_q[31] ^ t1_q[31];
		end else if (cmd.st == S_DIV) begin
			dv_r_q <= r_diff[32] ? r_sh[31:0] : r_diff[31:0];
			dv_n_q <= {dv_n_q[30:0], ~r_diff[32]};
		end
		if (cmd.st == S_FIN && stat.out_free) begin
			nip_out_q <= pc_q;
			halted_out_q <= stopped_q;
			err_out_q <= err_q;
			if (stop_in_q) value_out_q <= '0;
			else if (halt_q) value_out_q <= t1_q;
			else value_out_q <= c_ge1 ? sd_q : 32'd0;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			cnt_q <= '0;
			fb_q <= '0;
			acnt_q <= '0;
			wused_q <= '0;
			ccnt_q <= '0;
			stopped_q <= 1'b0;
			stop_in_q <= 1'b0;
			halt_q <= 1'b0;
			err_q <= ERR_NONE;
			slot_v_q <= '0;
			slot_vq <= 1'b0;
			k_q <= '0;
			dv_k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd.st == S_FIN && stat.out_free) || (out_valid_q && !out_ready);
			if (cmd.load) begin
				stop_in_q <= stopped_q;
				halt_q <= 1'b0;
				err_q <= ERR_NONE;
			end
			if (cmd.st == S_RD1) slot_vq <= slot_v_q[SW'(imm_q)];
			if (sl_we) slot_v_q[sl_wa] <= 1'b1;
			if (cmd.st == S_EXEC) begin
				k_q <= '0;
				dv_k_q <= '0;
				if (err_e != ERR_NONE) begin
					stopped_q <= 1'b1;
					err_q <= err_e;
				end else begin
					unique case (op_q) inside
						OP_HALT: begin
							cnt_q <= c_m1; halt_q <= 1'b1; stopped_q <= 1'b1;
						end
						OP_NOP, OP_NEG: pc_q <= pc_q + 16'd1;
						OP_PUSH, OP_LOAD: begin
							cnt_q <= cnt_q + SCW'(1); pc_q <= pc_q + 16'd2;
						end
						OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_GT: begin
							cnt_q <= c_m1; pc_q <= pc_q + 16'd1;
						end
						OP_STORE: begin
							cnt_q <= c_m1; pc_q <= pc_q + 16'd2;
						end
						OP_JMP: pc_q <= tgt_q;
						OP_JMPF: begin
							cnt_q <= c_m1;
							pc_q <= (t1_q == 32'd0) ? tgt_q : pc_q + 16'd3;
						end
						OP_CALL: ccnt_q <= ccnt_q + CCW'(1);
						default: pc_q <= pc_q;
					endcase
				end
			end
			if (cmd.st == S_DIV) dv_k_q <= dv_k_q + 5'd1;
			if (cmd.st == S_DIVW) begin
				cnt_q <= c_m1; pc_q <= pc_q + 16'd1;
			end
			if (cmd.st == S_COPY) begin
				k_q <= k_q + KW'(1);
				if (k_q == sz_k) begin
					cnt_q <= base_c + SCW'(1);
					acnt_q <= acnt_q + ACW'(1);
					wused_q <= wused_q + WCW'(t1_q);
					pc_q <= pc_q + 16'd1;
				end
			end
			if (cmd.st == S_ADESC) begin
				if (desc_bad) begin
					stopped_q <= 1'b1;
					err_q <= ERR_INDEX;
				end else if (!is_aload) begin
					cnt_q <= c_m2; pc_q <= pc_q + 16'd1;
				end
			end
			if (cmd.st == S_AWRD) begin
				cnt_q <= c_m1; pc_q <= pc_q + 16'd1;
			end
			if (cmd.st == S_CALL) begin
				k_q <= k_q + KW'(1);
				if (k_q == na_k) begin
					fb_q <= fb_q + SW'(t2_q);
					cnt_q <= c_m2 - SCW'(t2_q);
					pc_q <= t1_q[15:0];
				end
			end
			if (cmd.st == S_RETW) begin
				pc_q <= csip_q;
				fb_q <= csfb_q;
				ccnt_q <= ccnt_q - CCW'(1);
			end
		end
	end

	always_comb begin
		stat.stopped = stopped_q;
		stat.exec_err = (err_e != ERR_NONE);
		stat.desc_err = desc_bad;
		stat.is_aload = is_aload;
		stat.div_last = (dv_k_q == 5'd31);
		stat.copy_last = (k_q == sz_k);
		stat.call_last = (k_q == na_k);
		stat.out_free = !out_valid_q || out_ready;
		stat.cls = cls;
	end

	assign out_valid = out_valid_q;
	assign next_ip = nip_out_q;
	assign halted = halted_out_q;
	assign value = value_out_q;
	assign error = err_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SCW'(STACK_DEPTH))
		else $error("operand stack count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q <= CCW'(CALL_DEPTH))
		else $error("call stack count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		wused_q <= WCW'(ARRAY_WORD_COUNT))
		else $error("array words used beyond store size");
	assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("core left the stopped state without reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_out_q != ERR_NONE) |-> halted_out_q)
		else $error("error reported without halted");

endmodule

/* design/stack_bytecode_vm_core_unit.sv */
// Sequence: after the item is accepted, a plain instruction passes through RD1, RD2, RD3,
// EXEC, TOP and FIN, and the core takes the next item in IDLE once the output register is free.
// Divide adds the DIV and DIVW states (one quotient bit per cycle), while array create and call
// copy their elements and arguments one at a time through the one read port of the stack memory.
// A core that is stopped goes from IDLE straight to FIN for each item.
// Reset is asynchronous and active low; it clears all counters and slot valid bits at once.
module stack_bytecode_vm_core_unit #(
	parameter int STACK_DEPTH      = 1024,
	parameter int SLOT_COUNT       = 256,
	parameter int ARRAY_SLOTS      = 1024,
	parameter int ARRAY_WORD_COUNT = 4096,
	parameter int CALL_DEPTH       = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         op,
	input  logic [7:0]         imm,
	input  logic [15:0]        target,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_ip,
	output logic               halted,
	output logic signed [31:0] value,
	output logic [3:0]         error
);
	import sbvm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sbvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbvm_dp #(
		.STACK_DEPTH      (STACK_DEPTH),
		.SLOT_COUNT       (SLOT_COUNT),
		.ARRAY_SLOTS      (ARRAY_SLOTS),
		.ARRAY_WORD_COUNT (ARRAY_WORD_COUNT),
		.CALL_DEPTH       (CALL_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op        (op),
		.imm       (imm),
		.target    (target),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.next_ip   (next_ip),
		.halted    (halted),
		.value     (value),
		.error     (error)
	);

endmodule
